// ===== hw/rtl/multi_mode_bit_serial_crc_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-mode bit-serial CRC block
// Helpers for clocked concurrent checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef MULTI_MODE_BIT_SERIAL_CRC_TOP_MACROS_SVH
`define MULTI_MODE_BIT_SERIAL_CRC_TOP_MACROS_SVH

// Check cons in the same cycle as ante
`define MMCRC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante
`define MMCRC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/mmcrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mmcrc_pkg
// Types, constants and per-mode helper functions for the multi-mode CRC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mmcrc_pkg;

   localparam int unsigned CRC_W          = 32;
   localparam int unsigned COUNT_W        = 9;
   localparam int unsigned MAX_FRAME_BITS = 256;
   localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

   typedef enum logic [2:0] {
      CRC_MODE_CRC16 = 3'd0,
      CRC_MODE_CRC9  = 3'd1,
      CRC_MODE_CRC32 = 3'd2,
      CRC_MODE_CRC8  = 3'd3,
      CRC_MODE_CRC7  = 3'd4
   } crc_mode_type;

   typedef struct packed {
      logic [CRC_W-1:0]   sr;
      logic [COUNT_W-1:0] count;
   } crc_state_type;

   // Register width of each mode
   function automatic logic [5:0] mode_width(input crc_mode_type mode);
      logic [5:0] w;
      case (mode)
         CRC_MODE_CRC9:  w = 6'd9;
         CRC_MODE_CRC32: w = 6'd32;
         CRC_MODE_CRC8:  w = 6'd8;
         CRC_MODE_CRC7:  w = 6'd7;
         default:        w = 6'd16;
      endcase
      return w;
   endfunction

   // Mask that keeps the register within the mode width
   function automatic logic [CRC_W-1:0] mode_mask(input crc_mode_type mode);
      logic [CRC_W-1:0] m;
      case (mode)
         CRC_MODE_CRC9:  m = 32'h0000_01FF;
         CRC_MODE_CRC32: m = 32'hFFFF_FFFF;
         CRC_MODE_CRC8:  m = 32'h0000_00FF;
         CRC_MODE_CRC7:  m = 32'h0000_007F;
         default:        m = 32'h0000_FFFF;
      endcase
      return m;
   endfunction

   // Generator polynomial without the top term
   function automatic logic [CRC_W-1:0] mode_poly(input crc_mode_type mode);
      logic [CRC_W-1:0] p;
      case (mode)
         CRC_MODE_CRC9:  p = 32'h0000_0059;
         CRC_MODE_CRC32: p = 32'h04C1_1DB7;
         CRC_MODE_CRC8:  p = 32'h0000_0007;
         CRC_MODE_CRC7:  p = 32'h0000_0027;
         default:        p = 32'h0000_1021;
      endcase
      return p;
   endfunction

   // Top bit of the register for the mode width
   function automatic logic mode_msb(input crc_mode_type mode,
                                     input logic [CRC_W-1:0] sr);
      logic b;
      case (mode)
         CRC_MODE_CRC9:  b = sr[8];
         CRC_MODE_CRC32: b = sr[31];
         CRC_MODE_CRC8:  b = sr[7];
         CRC_MODE_CRC7:  b = sr[6];
         default:        b = sr[15];
      endcase
      return b;
   endfunction

endpackage

// ===== hw/rtl/multi_mode_bit_serial_crc_top.sv =====
// ----------------------------------------------------------------------------
// multi_mode_bit_serial_crc_top
// Bit-serial CRC engine with five selectable CRC modes and a match flag.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one message bit per transaction, MSB first,
//   with req_last_bit marking the frame end and req_expected_crc the CRC to
//   compare against (sampled only with the last bit).
//   The rsp_ channel returns one transaction per frame: the finished CRC,
//   right aligned, and a flag that is set when it equals all 32 bits of
//   req_expected_crc.
//   csr_wr_en / csr_wr_data write the mode (0 CRC-16 inverted, 1 CRC-9
//   inverted, 2 CRC-32 byte swapped, 3 CRC-8, 4 CRC-7); codes 5-7 are ignored.
// Timing:
//   One bit is taken every cycle while req_stall is low. The LFSR step and the finishing logic sit
//   between the CRC state register and the result register, so the result
//   appears in the cycle after the last bit is taken.
// Reset:
//   Clears the CRC register, the bit count, the result valid and sets mode 0.
// Stall:
//   The result register holds while rsp_stall is high; req_stall rises only
//   while a result is held there.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_mode_bit_serial_crc_top #(
   parameter int unsigned MAX_FRAME_BITS = mmcrc_pkg::MAX_FRAME_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   // input transactions
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_data_bit,
   input  logic                        req_last_bit,
   input  logic [mmcrc_pkg::CRC_W-1:0] req_expected_crc,
   // result transactions
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [mmcrc_pkg::CRC_W-1:0] rsp_crc_value,
   output logic                        rsp_crc_match,
   // mode register
   input  logic                        csr_wr_en,
   input  logic [2:0]                  csr_wr_data
);
   import mmcrc_pkg::*;

   crc_mode_type     mode_ff, mode_in;
   crc_state_type    state_ff, state_in;
   crc_state_type    state_step;
   logic [CRC_W-1:0] crc_final;
   logic             req_fire;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CRC_W-1:0] rsp_crc_value_ff, rsp_crc_value_in;
   logic             rsp_crc_match_ff, rsp_crc_match_in;

   // Hold input only while a result waits on a stalled receiver
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;

   mmcrc_step u_step (
      .mode       (mode_ff),
      .state_cur  (state_ff),
      .data_bit   (req_data_bit),
      .state_next (state_step)
   );

   mmcrc_finish #(
      .MAX_FRAME_BITS (MAX_FRAME_BITS)
   ) u_finish (
      .mode      (mode_ff),
      .state_new (state_step),
      .crc_value (crc_final)
   );

   // Mode register: take only defined codes
   always_comb begin
      mode_in = mode_ff;
      if (csr_wr_en && csr_wr_data <= 3'(CRC_MODE_CRC7)) begin
         mode_in = crc_mode_type'(csr_wr_data);
      end
   end

   // CRC state: advance per transaction, clear after the last bit
   always_comb begin
      state_in = state_ff;
      if (req_fire) begin
         state_in = req_last_bit ? '0 : state_step;
      end
   end

   // Result register: load on the last bit, drop once taken
   always_comb begin
      rsp_valid_in     = rsp_valid_ff & rsp_stall;
      rsp_crc_value_in = rsp_crc_value_ff;
      rsp_crc_match_in = rsp_crc_match_ff;
      if (req_fire && req_last_bit) begin
         rsp_valid_in     = 1'b1;
         rsp_crc_value_in = crc_final;
         rsp_crc_match_in = (crc_final == req_expected_crc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= CRC_MODE_CRC16;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_crc_value_ff <= rsp_crc_value_in;
      rsp_crc_match_ff <= rsp_crc_match_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = rsp_crc_value_ff;
   assign rsp_crc_match = rsp_crc_match_ff;

`include "multi_mode_bit_serial_crc_top_macros.svh"

   `MMCRC_ASSERT_NEXT(a_last_gives_result, clock, reset, req_fire && req_last_bit, rsp_valid_ff, "last bit produced no result")
   `MMCRC_ASSERT_NEXT(a_last_clears_state, clock, reset, req_fire && req_last_bit, state_ff == '0, "state not cleared after frame end")
   `MMCRC_ASSERT_NEXT(a_count_advance, clock, reset, req_fire && !req_last_bit && state_ff.count != COUNT_SAT, state_ff.count == $past(state_ff.count) + COUNT_W'(1), "bit count did not advance")
   `MMCRC_ASSERT_NEXT(a_bad_mode_ignored, clock, reset, csr_wr_en && csr_wr_data > 3'(CRC_MODE_CRC7), $stable(mode_ff), "undefined mode code was taken")
   `MMCRC_ASSERT_SAME(a_idle_state_holds, clock, reset, !req_fire && !csr_wr_en, state_in == state_ff, "state moved without a transaction")

endmodule

// ===== hw/rtl/mmcrc_step.sv =====
// ----------------------------------------------------------------------------
// mmcrc_step
// One LFSR step for the selected mode plus the saturating frame bit count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmcrc_step (
   input  mmcrc_pkg::crc_mode_type  mode,
   input  mmcrc_pkg::crc_state_type state_cur,
   input  logic                     data_bit,
   output mmcrc_pkg::crc_state_type state_next
);
   import mmcrc_pkg::*;

   logic [CRC_W-1:0] mask;
   logic [CRC_W-1:0] sr_masked;
   logic [CRC_W-1:0] sr_shift;
   logic             feedback;

   // Drop bits above the current width, then shift and fold in the polynomial
   always_comb begin
      mask      = mode_mask(mode);
      sr_masked = state_cur.sr & mask;
      feedback  = mode_msb(mode, sr_masked) ^ data_bit;
      sr_shift  = {sr_masked[CRC_W-2:0], 1'b0} & mask;
      state_next.sr = feedback ? (sr_shift ^ mode_poly(mode)) : sr_shift;

      // Advance the bit count, hold at saturation
      if (state_cur.count != COUNT_SAT) begin
         state_next.count = state_cur.count + COUNT_W'(1);
      end else begin
         state_next.count = state_cur.count;
      end
   end

endmodule

// ===== hw/rtl/mmcrc_finish.sv =====
// ----------------------------------------------------------------------------
// mmcrc_finish
// Finishing step per mode: inversion, byte swap or long-frame zeroing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmcrc_finish #(
   parameter int unsigned MAX_FRAME_BITS = mmcrc_pkg::MAX_FRAME_BITS
) (
   input  mmcrc_pkg::crc_mode_type   mode,
   input  mmcrc_pkg::crc_state_type  state_new,
   output logic [mmcrc_pkg::CRC_W-1:0] crc_value
);
   import mmcrc_pkg::*;

   localparam logic [COUNT_W:0] LIMIT = (COUNT_W+1)'(MAX_FRAME_BITS);

   logic [COUNT_W:0] len_plus_w;
   logic             too_long;
   logic [CRC_W-1:0] sr;

   // Frame length plus CRC width against the frame limit
   always_comb begin
      len_plus_w = {1'b0, state_new.count} + (COUNT_W+1)'(mode_width(mode));
      too_long   = len_plus_w > LIMIT;
      sr         = state_new.sr & mode_mask(mode);
   end

   // Select the finished value
   always_comb begin
      case (mode)
         CRC_MODE_CRC9: begin
            crc_value = {23'd0, sr[8:0] ^ 9'h1FF};
         end
         CRC_MODE_CRC32: begin
            crc_value = {sr[7:0], sr[15:8], sr[23:16], sr[31:24]};
         end
         CRC_MODE_CRC8, CRC_MODE_CRC7: begin
            crc_value = too_long ? '0 : sr;
         end
         default: begin
            crc_value = {16'd0, sr[15:0] ^ 16'hFFFF};
         end
      endcase
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-mode bit-serial CRC block. A driver feeds
// message bits from a queue with random gaps, a monitor stalls results at
// random and compares each one against a bit-level CRC predictor run on every
// accepted bit. Covers all five modes, ignored mode codes, mode changes inside
// a frame and the long-frame rule of the 8-bit CRC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import mmcrc_pkg::*;

   localparam int unsigned RUN_LIMIT     = 1_000_000;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned DRAIN_CYCLES  = 10;
   localparam int unsigned HOLD_CYCLES   = 80;
   localparam int unsigned RANDOM_BITS   = 80;
   localparam logic [2:0]  MODE_SPARE_LO = 3'd5;
   localparam logic [2:0]  MODE_SPARE_HI = 3'd7;

   typedef enum {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_kind_type;
   typedef enum {CHK_GOOD, CHK_RANDOM, CHK_FLIP, CHK_ZERO} check_kind_type;

   typedef struct packed {
      logic             data_bit;
      logic             last_bit;
      logic [CRC_W-1:0] expected_crc;
   } serial_bit_type;

   typedef struct packed {
      logic [CRC_W-1:0] crc;
      logic             crc_hit;
   } crc_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_data_bit = 1'b0;
   logic               req_last_bit = 1'b0;
   logic [CRC_W-1:0]   req_expected_crc = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [CRC_W-1:0]   rsp_crc_value;
   logic               rsp_crc_match;
   logic               csr_wr_en = 1'b0;
   logic [2:0]         csr_wr_data = '0;

   serial_bit_type     pending_bits_q[$];
   crc_result_type     crc_expected_q[$];
   serial_bit_type     shown_bit;

   // predictor state, advanced on accepted bits
   crc_mode_type       model_mode = CRC_MODE_CRC16;
   logic [CRC_W-1:0]   model_sr = '0;
   logic [COUNT_W-1:0] model_count = '0;

   // generator state, advanced as bits are queued
   crc_mode_type       gen_mode = CRC_MODE_CRC16;
   logic [CRC_W-1:0]   gen_sr = '0;
   logic [COUNT_W-1:0] gen_count = '0;

   logic               idle_on = 1'b1;
   logic               hold_kick = 1'b0;
   int unsigned        hold_left = 0;
   int unsigned        send_gap = 0;
   int unsigned        stall_left = 0;
   int unsigned        mismatch_count = 0;
   int unsigned        cycle_count = 0;

   multi_mode_bit_serial_crc_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_bit     (req_data_bit),
      .req_last_bit     (req_last_bit),
      .req_expected_crc (req_expected_crc),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_crc_value    (rsp_crc_value),
      .rsp_crc_match    (rsp_crc_match),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #10 clock = ~clock;

   // CRC arithmetic ----------------------------------------------------------

   function automatic int unsigned crc_width(input crc_mode_type m);
      case (m)
         CRC_MODE_CRC9:  return 9;
         CRC_MODE_CRC32: return 32;
         CRC_MODE_CRC8:  return 8;
         CRC_MODE_CRC7:  return 7;
         default:        return 16;
      endcase
   endfunction

   function automatic logic [CRC_W-1:0] crc_poly(input crc_mode_type m);
      case (m)
         CRC_MODE_CRC9:  return 32'h0000_0059;
         CRC_MODE_CRC32: return 32'h04C1_1DB7;
         CRC_MODE_CRC8:  return 32'h0000_0007;
         CRC_MODE_CRC7:  return 32'h0000_0027;
         default:        return 32'h0000_1021;
      endcase
   endfunction

   // One LFSR step; bits above the current width drop out
   function automatic logic [CRC_W-1:0] crc_shift_bit(input crc_mode_type m,
                                                      input logic [CRC_W-1:0] sr,
                                                      input logic d);
      int unsigned      w;
      logic [CRC_W-1:0] msk;
      logic             fb;
      w   = crc_width(m);
      msk = (w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
      sr  = sr & msk;
      fb  = sr[w-1] ^ d;
      sr  = (sr << 1) & msk;
      if (fb) begin
         sr = sr ^ crc_poly(m);
      end
      return sr;
   endfunction

   // Finishing step at the end of a frame
   function automatic logic [CRC_W-1:0] crc_finish(input crc_mode_type m,
                                                   input logic [CRC_W-1:0] sr,
                                                   input logic [COUNT_W-1:0] count);
      case (m)
         CRC_MODE_CRC9:  return (sr & 32'h0000_01FF) ^ 32'h0000_01FF;
         CRC_MODE_CRC32: return {sr[7:0], sr[15:8], sr[23:16], sr[31:24]};
         CRC_MODE_CRC8, CRC_MODE_CRC7: begin
            if (int'(count) + crc_width(m) > MAX_FRAME_BITS) begin
               return '0;
            end
            return sr;
         end
         default:        return (sr & 32'h0000_FFFF) ^ 32'h0000_FFFF;
      endcase
   endfunction

   // Advance the predictor with one accepted bit
   task automatic crc_accept_bit(input serial_bit_type b);
      crc_result_type r;
      model_sr = crc_shift_bit(model_mode, model_sr, b.data_bit);
      if (model_count != COUNT_SAT) begin
         model_count = model_count + COUNT_W'(1);
      end
      if (b.last_bit) begin
         r.crc     = crc_finish(model_mode, model_sr, model_count);
         r.crc_hit = (r.crc == b.expected_crc);
         crc_expected_q.push_back(r);
         model_sr    = '0;
         model_count = '0;
      end
   endtask

   // Stimulus helpers --------------------------------------------------------

   // Mostly short gaps, a few long ones, none while idling is off
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (!idle_on) begin
         return 0;
      end
      r = $urandom_range(99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(40, 8);
   endfunction

   // Queue one frame; an open frame has no last bit
   task automatic queue_frame(input int unsigned len, input fill_kind_type fill,
                              input check_kind_type chk, input bit close);
      serial_bit_type   b;
      logic [CRC_W-1:0] crc;
      int unsigned      i;
      for (i = 0; i < len; i++) begin
         case (fill)
            FILL_ONES:  b.data_bit = 1'b1;
            FILL_ZEROS: b.data_bit = 1'b0;
            default:    b.data_bit = 1'($urandom_range(1));
         endcase
         b.last_bit     = close && (i == len - 1);
         b.expected_crc = $urandom;
         gen_sr = crc_shift_bit(gen_mode, gen_sr, b.data_bit);
         if (gen_count != COUNT_SAT) begin
            gen_count = gen_count + COUNT_W'(1);
         end
         if (b.last_bit) begin
            crc = crc_finish(gen_mode, gen_sr, gen_count);
            case (chk)
               CHK_GOOD: b.expected_crc = crc;
               CHK_FLIP: b.expected_crc = crc ^ (32'd1 << $urandom_range(31));
               CHK_ZERO: b.expected_crc = '0;
               default:  ;
            endcase
            gen_sr    = '0;
            gen_count = '0;
         end
         pending_bits_q.push_back(b);
      end
   endtask

   function automatic check_kind_type pick_check();
      int unsigned r;
      r = $urandom_range(9);
      if (r < 4) begin
         return CHK_GOOD;
      end else if (r < 7) begin
         return CHK_RANDOM;
      end else if (r < 9) begin
         return CHK_FLIP;
      end
      return CHK_ZERO;
   endfunction

   // Wait for every transaction and result to drain, then write the mode
   task automatic set_crc_mode(input logic [2:0] code);
      do begin
         @(negedge clock);
      end while (pending_bits_q.size() != 0 || req_valid || crc_expected_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= code;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 3'($urandom_range(7));
      if (code <= 3'(CRC_MODE_CRC7)) begin
         model_mode = crc_mode_type'(code);
         gen_mode   = crc_mode_type'(code);
      end
      @(negedge clock);
   endtask

   task automatic kick_hold();
      @(posedge clock);
      hold_kick <= 1'b1;
      @(posedge clock);
      hold_kick <= 1'b0;
   endtask

   // Driver: present queued bits, hold while stalled ------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            crc_accept_bit(shown_bit);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap = send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_bits_q.size() != 0) begin
               shown_bit = pending_bits_q.pop_front();
               req_data_bit     <= shown_bit.data_bit;
               req_last_bit     <= shown_bit.last_bit;
               req_expected_crc <= shown_bit.expected_crc;
               req_valid        <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_kick) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: compare each accepted result with the oldest expectation -----

   task automatic log_mismatch(input string what, input crc_result_type want);
      if (mismatch_count < 10) begin
         $display("crc result %s: expected crc %h match %b, got crc %h match %b",
                  what, want.crc, want.crc_hit, rsp_crc_value, rsp_crc_match);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      crc_result_type want;
      logic           nxt_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (crc_expected_q.size() == 0) begin
               log_mismatch("with nothing pending", '0);
            end else begin
               want = crc_expected_q.pop_front();
               if (rsp_crc_value !== want.crc || rsp_crc_match !== want.crc_hit) begin
                  log_mismatch("differs", want);
               end
            end
         end
         if (stall_left == 0) begin
            stall_left = pick_gap();
         end
         nxt_stall = 1'b0;
         if (stall_left != 0) begin
            stall_left = stall_left - 1;
            nxt_stall  = 1'b1;
         end
         rsp_stall <= nxt_stall || (hold_left != 0);
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Stimulus sequence ------------------------------------------------------

   initial begin
      int unsigned random_bits;
      int unsigned frames;
      int unsigned len;
      int unsigned f;
      logic [2:0]  code;

      random_bits = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // mode out of reset, single-bit frames and an all-ones word
      queue_frame(1, FILL_ZEROS, CHK_GOOD, 1'b1);
      queue_frame(1, FILL_ONES, CHK_RANDOM, 1'b1);
      queue_frame(16, FILL_ONES, CHK_FLIP, 1'b1);

      // each mode once
      set_crc_mode(CRC_MODE_CRC9);
      queue_frame(12, FILL_RANDOM, CHK_GOOD, 1'b1);
      set_crc_mode(CRC_MODE_CRC32);
      queue_frame(32, FILL_ONES, CHK_GOOD, 1'b1);
      set_crc_mode(CRC_MODE_CRC8);
      queue_frame(8, FILL_RANDOM, CHK_GOOD, 1'b1);
      set_crc_mode(CRC_MODE_CRC7);
      queue_frame(7, FILL_ZEROS, CHK_ZERO, 1'b1);

      // spare mode codes leave the mode alone
      set_crc_mode(MODE_SPARE_LO);
      queue_frame(5, FILL_RANDOM, CHK_GOOD, 1'b1);
      set_crc_mode(MODE_SPARE_HI);
      queue_frame(3, FILL_RANDOM, CHK_FLIP, 1'b1);

      // long-frame rule: frame length plus CRC width just past the limit
      set_crc_mode(CRC_MODE_CRC8);
      queue_frame(249, FILL_RANDOM, CHK_ZERO, 1'b1);

      // switch modes inside a frame, wide to narrow and back
      set_crc_mode(CRC_MODE_CRC32);
      queue_frame(20, FILL_ONES, CHK_GOOD, 1'b0);
      set_crc_mode(CRC_MODE_CRC9);
      queue_frame(5, FILL_RANDOM, CHK_GOOD, 1'b1);
      set_crc_mode(CRC_MODE_CRC16);
      queue_frame(10, FILL_RANDOM, CHK_GOOD, 1'b0);
      set_crc_mode(CRC_MODE_CRC32);
      queue_frame(6, FILL_RANDOM, CHK_GOOD, 1'b1);

      // hold results off while short frames keep coming
      set_crc_mode(CRC_MODE_CRC7);
      idle_on = 1'b0;
      for (f = 0; f < 10; f++) begin
         len = $urandom_range(4, 1);
         queue_frame(len, FILL_RANDOM, pick_check(), 1'b1);
         random_bits += len;
      end
      kick_hold();

      // random phases
      while (random_bits < RANDOM_BITS) begin
         code = 3'($urandom_range(7));
         set_crc_mode(code);
         idle_on = ($urandom_range(3) != 0);
         frames  = $urandom_range(6, 1);
         for (f = 0; f < frames; f++) begin
            len = $urandom_range(24, 1);
            queue_frame(len, FILL_RANDOM, pick_check(),
                        (f != frames - 1) || ($urandom_range(3) != 0));
            random_bits += len;
         end
         if ($urandom_range(7) == 0) begin
            kick_hold();
         end
      end

      // drain and settle
      do begin
         @(negedge clock);
      end while (pending_bits_q.size() != 0 || req_valid || crc_expected_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && crc_expected_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mmcrc_pkg.sv
hw/rtl/mmcrc_step.sv
hw/rtl/mmcrc_finish.sv
hw/rtl/multi_mode_bit_serial_crc_top.sv
tb/sv/tb_top.sv
